// ===== sv/bcs_pkg.sv =====
`default_nettype none

package bcs_pkg;

    localparam int BCS_COORD_BITS = 16;
    localparam int BCS_SAMPLES    = 10;
    localparam int BCS_LANES      = 4;
    localparam int BCS_INDEX_BITS = 4;

    localparam logic [1:0] BCS_DEGREE_QUAD  = 2'd2;
    localparam logic [1:0] BCS_DEGREE_CUBIC = 2'd3;
    localparam logic [1:0] BCS_DEGREE_RESET = BCS_DEGREE_CUBIC;

    typedef logic signed [BCS_COORD_BITS-1:0] bcs_coord_t;

    typedef struct packed {
        bcs_coord_t y;
        bcs_coord_t x;
    } bcs_point_t;

    // One segment to sample, or one error result.
    typedef struct packed {
        bcs_point_t [BCS_LANES-1:0] pts;
        logic                       cubic;
        logic                       closing;
        logic                       bad;
    } bcs_job_t;

    // Sideband that travels with each sample down the pipeline.
    typedef struct packed {
        logic [BCS_INDEX_BITS-1:0] k;
        logic                      seg_done;
        logic                      curve_done;
        logic                      bad;
        logic                      cubic;
    } bcs_tag_t;

    // Bits of the largest Bernstein weight, SAMPLES^3.
    function automatic int bcs_wbits(int samples);
        return $clog2(samples ** 3 + 1);
    endfunction

endpackage

`default_nettype wire

// ===== sv/bcs_front.sv =====
`default_nettype none

module bcs_front import bcs_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    input  wire logic [1:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire bcs_coord_t s_point_x,
    input  wire bcs_coord_t s_point_y,
    input  wire logic       s_last,
    output logic            job_valid,
    output bcs_job_t        job,
    input  wire logic       job_ready
);

    logic [1:0]  degree_reg;
    bcs_point_t  first_reg, first_next;
    bcs_point_t  seg_reg [3];
    bcs_point_t  seg_next [3];
    logic [1:0]  held_reg, held_next;
    logic        open_reg, open_next;
    logic        job_valid_reg, job_valid_next;
    bcs_job_t    job_reg, job_new;

    logic        cubic;
    logic [1:0]  deg;
    logic        emit;
    logic        accept;
    bcs_point_t  pt;

    assign s_ready   = aresetn && (!job_valid_reg || job_ready);
    assign accept    = s_valid && s_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb begin
        cubic      = (degree_reg == BCS_DEGREE_CUBIC);
        deg        = cubic ? BCS_DEGREE_CUBIC : BCS_DEGREE_QUAD;
        pt.x       = s_point_x;
        pt.y       = s_point_y;
        first_next = first_reg;
        seg_next   = seg_reg;
        held_next  = held_reg;
        open_next  = open_reg;
        emit       = 1'b0;
        job_new    = '0;
        job_new.cubic = cubic;

        if (!open_reg) begin
            first_next  = pt;
            seg_next[0] = pt;
            held_next   = 2'd1;
            open_next   = 1'b1;
            if (s_last) begin
                // one-point curve
                open_next   = 1'b0;
                held_next   = 2'd0;
                emit        = 1'b1;
                job_new.bad = 1'b1;
            end
        end else if (s_last) begin
            open_next = 1'b0;
            held_next = 2'd0;
            emit      = 1'b1;
            if (held_reg != deg - 2'd1) begin
                job_new.bad = 1'b1;
            end else if (cubic) begin
                job_new.pts[0]  = seg_reg[0];
                job_new.pts[1]  = seg_reg[1];
                job_new.pts[2]  = pt;
                job_new.pts[3]  = first_reg;
                job_new.closing = 1'b1;
            end else begin
                job_new.pts[0]  = seg_reg[0];
                job_new.pts[1]  = pt;
                job_new.pts[2]  = first_reg;
                job_new.pts[3]  = first_reg;
                job_new.closing = 1'b1;
            end
        end else if (held_reg >= deg) begin
            emit           = 1'b1;
            job_new.pts[0] = seg_reg[0];
            job_new.pts[1] = seg_reg[1];
            job_new.pts[2] = cubic ? seg_reg[2] : pt;
            job_new.pts[3] = pt;
            seg_next[0]    = pt;
            held_next      = 2'd1;
        end else begin
            seg_next[held_reg] = pt;
            held_next          = held_reg + 2'd1;
        end

        job_valid_next = job_valid_reg;
        if (job_ready) begin
            job_valid_next = 1'b0;
        end
        if (accept && emit) begin
            job_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg    <= BCS_DEGREE_RESET;
            held_reg      <= 2'd0;
            open_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                degree_reg <= cfg_data;
            end
            if (accept) begin
                held_reg <= held_next;
                open_reg <= open_next;
            end
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            first_reg <= first_next;
            seg_reg   <= seg_next;
            if (emit) begin
                job_reg <= job_new;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bcs_lane.sv =====
`default_nettype none

module bcs_lane import bcs_pkg::*; #(
    parameter int SAMPLES = BCS_SAMPLES,
    parameter int LANE    = 0
) (
    input  wire logic                           aclk,
    input  wire logic                           advance,
    input  wire logic [BCS_INDEX_BITS-1:0]      k,
    input  wire logic                           cubic,
    input  wire bcs_point_t                     pt,
    output logic signed [BCS_COORD_BITS+bcs_wbits(SAMPLES)-1:0] prod_x,
    output logic signed [BCS_COORD_BITS+bcs_wbits(SAMPLES)-1:0] prod_y
);

    localparam int WB = bcs_wbits(SAMPLES);
    localparam int PW = BCS_COORD_BITS + WB;
    localparam int KB = $clog2(SAMPLES);

    // C(d,j) * (SAMPLES-k)^(d-j) * k^j, zero for a lane beyond the degree
    function automatic int lane_weight(int d, int j, int kk);
        int w;
        w = (j == 0 || j == d) ? 1 : d;
        for (int i = 0; i < d - j; i++) begin
            w = w * (SAMPLES - kk);
        end
        for (int i = 0; i < j; i++) begin
            w = w * kk;
        end
        if (j > d) begin
            w = 0;
        end
        return w;
    endfunction

    logic [WB-1:0] wt2 [SAMPLES];
    logic [WB-1:0] wt3 [SAMPLES];

    for (genvar g = 0; g < SAMPLES; g++) begin : g_wt
        assign wt2[g] = WB'(lane_weight(2, LANE, g));
        assign wt3[g] = WB'(lane_weight(3, LANE, g));
    end

    logic [WB-1:0]      w;
    logic signed [PW:0] mx;
    logic signed [PW:0] my;
    logic signed [PW-1:0] prod_x_reg;
    logic signed [PW-1:0] prod_y_reg;

    always_comb begin
        w  = cubic ? wt3[k[KB-1:0]] : wt2[k[KB-1:0]];
        mx = $signed({1'b0, w}) * pt.x;
        my = $signed({1'b0, w}) * pt.y;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_x_reg <= mx[PW-1:0];
            prod_y_reg <= my[PW-1:0];
        end
    end

    assign prod_x = prod_x_reg;
    assign prod_y = prod_y_reg;

endmodule

`default_nettype wire

// ===== sv/bcs_merge.sv =====
`default_nettype none

module bcs_merge import bcs_pkg::*; #(
    parameter int SAMPLES = BCS_SAMPLES
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire logic     in_valid,
    input  wire bcs_tag_t in_tag,
    input  wire logic signed [BCS_COORD_BITS+bcs_wbits(SAMPLES)-1:0] prod_x [BCS_LANES],
    input  wire logic signed [BCS_COORD_BITS+bcs_wbits(SAMPLES)-1:0] prod_y [BCS_LANES],
    output logic          out_valid,
    output bcs_tag_t      out_tag,
    output bcs_coord_t    out_x,
    output bcs_coord_t    out_y
);

    localparam int WB = bcs_wbits(SAMPLES);
    localparam int PW = BCS_COORD_BITS + WB;
    localparam int SB = PW + 2;
    localparam int NB = BCS_COORD_BITS - 1 + WB;
    localparam int SH = NB;
    localparam longint DEN2 = SAMPLES ** 2;
    localparam longint DEN3 = SAMPLES ** 3;
    localparam longint RCP2 = (longint'(1) << SH) / DEN2;
    localparam longint RCP3 = (longint'(1) << SH) / DEN3;
    localparam int RB = $clog2(RCP2 + 1);
    localparam int MW = NB + RB;

    localparam logic [RB-1:0] RCP2_V  = RB'(RCP2);
    localparam logic [RB-1:0] RCP3_V  = RB'(RCP3);
    localparam logic [NB:0]   DEN2_V  = (NB+1)'(DEN2);
    localparam logic [NB:0]   DEN3_V  = (NB+1)'(DEN3);
    localparam logic [NB-1:0] HALF2_V = NB'(DEN2 / 2);
    localparam logic [NB-1:0] HALF3_V = NB'(DEN3 / 2);

    // sum stage
    logic                 s2_valid_reg;
    bcs_tag_t             s2_tag_reg;
    logic signed [SB-1:0] s2_sum_reg [2];
    logic signed [SB-1:0] s2_sum_next [2];

    // magnitude plus half stage
    logic                 s3_valid_reg;
    bcs_tag_t             s3_tag_reg;
    logic [NB-1:0]        s3_n_reg [2];
    logic [NB-1:0]        s3_n_next [2];
    logic                 s3_neg_reg [2];

    // reciprocal multiply stage
    logic                 s4_valid_reg;
    bcs_tag_t             s4_tag_reg;
    logic [NB-1:0]        s4_n_reg [2];
    logic                 s4_neg_reg [2];
    logic [BCS_COORD_BITS-1:0] s4_q_reg [2];
    logic [BCS_COORD_BITS-1:0] s4_q_next [2];

    // output stage
    logic                 out_valid_reg;
    bcs_tag_t             out_tag_reg;
    bcs_coord_t           out_reg [2];
    bcs_coord_t           out_next [2];

    always_comb begin
        logic signed [SB-1:0] mag;
        logic [MW-1:0]        mul;
        logic [NB:0]          qd;
        logic [NB:0]          rem;
        logic [BCS_COORD_BITS-1:0] q;
        logic [NB-1:0]        half;
        logic [RB-1:0]        rcp;
        logic [NB:0]          den;

        s2_sum_next[0] = '0;
        s2_sum_next[1] = '0;
        for (int l = 0; l < BCS_LANES; l++) begin
            s2_sum_next[0] = s2_sum_next[0] + SB'(prod_x[l]);
            s2_sum_next[1] = s2_sum_next[1] + SB'(prod_y[l]);
        end

        half = s2_tag_reg.cubic ? HALF3_V : HALF2_V;
        rcp  = s3_tag_reg.cubic ? RCP3_V : RCP2_V;
        den  = s4_tag_reg.cubic ? DEN3_V : DEN2_V;

        for (int a = 0; a < 2; a++) begin
            // round half away from zero on the magnitude
            mag          = s2_sum_reg[a][SB-1] ? -s2_sum_reg[a] : s2_sum_reg[a];
            s3_n_next[a] = NB'(mag) + half;

            // estimate is the true quotient or one below it
            mul          = MW'(s3_n_reg[a]) * MW'(rcp);
            s4_q_next[a] = BCS_COORD_BITS'(mul >> SH);

            qd  = (NB+1)'(s4_q_reg[a]) * den;
            rem = (NB+1)'(s4_n_reg[a]) - qd;
            q   = (rem >= den) ? s4_q_reg[a] + 1'b1 : s4_q_reg[a];
            out_next[a] = s4_neg_reg[a] ? -$signed(q) : $signed(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg  <= in_valid;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_tag_reg  <= in_tag;
            s3_tag_reg  <= s2_tag_reg;
            s4_tag_reg  <= s3_tag_reg;
            out_tag_reg <= s4_tag_reg;
            for (int a = 0; a < 2; a++) begin
                s2_sum_reg[a] <= s2_sum_next[a];
                s3_n_reg[a]   <= s3_n_next[a];
                s3_neg_reg[a] <= s2_sum_reg[a][SB-1];
                s4_n_reg[a]   <= s3_n_reg[a];
                s4_neg_reg[a] <= s3_neg_reg[a];
                s4_q_reg[a]   <= s4_q_next[a];
                out_reg[a]    <= out_next[a];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_x     = out_reg[0];
    assign out_y     = out_reg[1];

endmodule

`default_nettype wire

// ===== sv/closed_bezier_curve_sampler_unit.sv =====
`default_nettype none

// Channel   Dir  Handshake               Contents
// s_        in   s_tvalid / s_tready     one control point, s_tlast marks the curve's last
// m_        out  m_tvalid / m_tready     one sampled point, m_tlast ends a segment's run
// cfg_      in   cfg_valid / cfg_ready   degree register (3 cubic, else quadratic)
//
// Samples leave at one per cycle while m_tready does not hold them, set by the sample sequencer;
// a segment gives SAMPLES transactions, so a cubic curve gives SAMPLES samples per three input points.
// With the sequencer idle, a segment's first sample passes from the end point's transaction
// through the job register, sequencer, weight lanes, merge adder tree and three rounding stages.
// Reset (aresetn low, synchronous) closes any open curve, drops queued work and sets
// the degree to cubic. A result held by m_tready low freezes the whole sample pipeline;
// input points stall while a finished segment waits in the job register behind it.

module closed_bezier_curve_sampler_unit import bcs_pkg::*; #(
    parameter int SAMPLES = BCS_SAMPLES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] point_x, [31:16] point_y
    input  wire logic        s_tlast,   // last_point

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [15:0] out_x, [31:16] out_y,
                                        // [35:32] sample_index, [39:36] zero
    output logic             m_tlast,   // segment_done
    output logic [1:0]       m_tuser,   // [0] curve_done, [1] bad_length

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data   // degree
);

    localparam int PW = BCS_COORD_BITS + bcs_wbits(SAMPLES);

    logic       advance;
    logic       job_valid;
    logic       job_ready;
    bcs_job_t   job;

    bcs_job_t   cur_reg;
    logic       active_reg;
    logic [BCS_INDEX_BITS-1:0] k_reg;
    logic       last_sample;
    logic       issue;

    logic       s1_valid_reg;
    bcs_tag_t   s1_tag_reg;
    bcs_tag_t   issue_tag;

    logic signed [PW-1:0] prod_x [BCS_LANES];
    logic signed [PW-1:0] prod_y [BCS_LANES];

    logic       out_valid;
    bcs_tag_t   out_tag;
    bcs_coord_t out_x;
    bcs_coord_t out_y;

    // Take configuration writes on any cycle out of reset.
    assign cfg_ready = aresetn;

    // Hold every pipeline stage while a result waits at the output.
    assign advance = !out_valid || m_tready;

    bcs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_point_x (s_tdata[15:0]),
        .s_point_y (s_tdata[31:16]),
        .s_last    (s_tlast),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready)
    );

    // Sample sequencer: walk k over the current segment, one sample per advance.
    // An error result is a single sample of all-zero points.
    assign last_sample = cur_reg.bad || (k_reg == BCS_INDEX_BITS'(SAMPLES - 1));
    assign issue       = active_reg && advance;
    assign job_ready   = !active_reg || (issue && last_sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            k_reg      <= '0;
        end else if (job_ready) begin
            active_reg <= job_valid;
            k_reg      <= '0;
        end else if (issue) begin
            k_reg <= k_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_ready && job_valid) begin
            cur_reg <= job;
        end
    end

    always_comb begin
        issue_tag.k          = k_reg;
        issue_tag.seg_done   = last_sample && !cur_reg.bad;
        issue_tag.curve_done = last_sample && (cur_reg.closing || cur_reg.bad);
        issue_tag.bad        = cur_reg.bad;
        issue_tag.cubic      = cur_reg.cubic;
    end

    // Sideband register alongside the lane product registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_tag_reg <= issue_tag;
        end
    end

    // One lane per control point: weight table lookup and multiply.
    for (genvar j = 0; j < BCS_LANES; j++) begin : g_lane
        bcs_lane #(
            .SAMPLES (SAMPLES),
            .LANE    (j)
        ) u_lane (
            .aclk    (aclk),
            .advance (advance),
            .k       (k_reg),
            .cubic   (cur_reg.cubic),
            .pt      (cur_reg.pts[j]),
            .prod_x  (prod_x[j]),
            .prod_y  (prod_y[j])
        );
    end

    // Sum the lanes and divide by SAMPLES^degree with rounding.
    bcs_merge #(
        .SAMPLES (SAMPLES)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s1_valid_reg),
        .in_tag    (s1_tag_reg),
        .prod_x    (prod_x),
        .prod_y    (prod_y),
        .out_valid (out_valid),
        .out_tag   (out_tag),
        .out_x     (out_x),
        .out_y     (out_y)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {4'b0000, out_tag.k, out_y, out_x};
    assign m_tlast  = out_tag.seg_done;
    assign m_tuser  = {out_tag.bad, out_tag.curve_done};

endmodule

`default_nettype wire

// ===== sim/closed_bezier_curve_sampler_unit_tb.sv =====
`timescale 1ns / 1ps

module closed_bezier_curve_sampler_unit_tb;
    import bcs_pkg::*;

    localparam int NSAMP         = BCS_SAMPLES;
    localparam int RANDOM_POINTS = 370;
    // Pause after the last sample before a degree write or the end of the run:
    // covers the sample pipeline plus a point still being buffered.
    localparam int DRAIN_CYCLES  = 16;
    // Cycles without any transaction before the run is declared hung.
    localparam int IDLE_LIMIT    = 1000;
    localparam int MAX_PRINTED   = 40;

    // Degree codes below 2 also select quadratic segments.
    localparam logic [1:0] DEGREE_ZERO = 2'd0;
    localparam logic [1:0] DEGREE_ONE  = 2'd1;

    typedef struct packed {
        bcs_coord_t y;
        bcs_coord_t x;
        logic       last;
    } ctrl_point_t;

    typedef struct {
        bcs_coord_t  x;
        bcs_coord_t  y;
        logic [3:0]  k;
        logic        seg_done;
        logic        curve_done;
        logic        bad;
    } curve_sample_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [15:0] point_x, [31:16] point_y
    logic        s_tlast   = 1'b0; // last_point
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // [15:0] out_x, [31:16] out_y, [35:32] sample_index
    logic        m_tlast;          // segment_done
    logic [1:0]  m_tuser;          // [0] curve_done, [1] bad_length
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = BCS_DEGREE_RESET;

    closed_bezier_curve_sampler_unit #(
        .SAMPLES(NSAMP)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Control points waiting to be driven, and samples the curve should produce.
    ctrl_point_t   point_q[$];
    curve_sample_t curve_samples_q[$];

    // Shadow of the block's state, advanced on every accepted degree write and control point.
    logic [1:0] degree_reg = BCS_DEGREE_RESET;
    bcs_coord_t anchor_x   = '0;
    bcs_coord_t anchor_y   = '0;
    bcs_coord_t held_x[3]  = '{default: '0};
    bcs_coord_t held_y[3]  = '{default: '0};
    int         held_cnt   = 0;
    bit         curve_open = 1'b0;

    int mismatches      = 0;
    int points_taken    = 0;
    int samples_checked = 0;
    int bad_results     = 0;
    int curves_closed   = 0;
    int degree_writes   = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Divide and round to nearest, ties away from zero.
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    // Queue the SAMPLES points of one segment with Bernstein weights scaled
    // by SAMPLES^d so that every weight is an integer.
    task automatic expect_segment(input longint cx[4], input longint cy[4],
                                  input int d, input bit closing);
        longint        den;
        longint        w;
        longint        sx;
        longint        sy;
        int            bj;
        curve_sample_t s;
        den = longint'(NSAMP) ** d;
        for (int k = 0; k < NSAMP; k++) begin
            sx = 0;
            sy = 0;
            for (int j = 0; j <= d; j++) begin
                bj = (j == 0 || j == d) ? 1 : d;
                w  = bj * (longint'(NSAMP - k) ** (d - j)) * (longint'(k) ** j);
                sx += w * cx[j];
                sy += w * cy[j];
            end
            s.x          = bcs_coord_t'(round_div(sx, den));
            s.y          = bcs_coord_t'(round_div(sy, den));
            s.k          = 4'(k);
            s.seg_done   = (k == NSAMP - 1);
            s.curve_done = (k == NSAMP - 1) && closing;
            s.bad        = 1'b0;
            curve_samples_q.push_back(s);
        end
    endtask

    task automatic expect_bad_length();
        curve_sample_t s;
        s.x          = '0;
        s.y          = '0;
        s.k          = '0;
        s.seg_done   = 1'b0;
        s.curve_done = 1'b1;
        s.bad        = 1'b1;
        curve_samples_q.push_back(s);
    endtask

    // Advance the curve state by one accepted control point.
    task automatic advance_curve(input bcs_coord_t px, input bcs_coord_t py,
                                 input logic last);
        int     d;
        longint cx[4];
        longint cy[4];
        d = (degree_reg == BCS_DEGREE_CUBIC) ? 3 : 2;
        if (last)
            curves_closed++;
        if (!curve_open) begin
            // Open a curve: this point is both the anchor and the first held point.
            anchor_x   = px;
            anchor_y   = py;
            held_x[0]  = px;
            held_y[0]  = py;
            held_cnt   = 1;
            curve_open = 1'b1;
            if (last) begin
                curve_open = 1'b0;
                held_cnt   = 0;
                expect_bad_length();
            end
        end else if (last) begin
            curve_open = 1'b0;
            if (held_cnt != d - 1) begin
                held_cnt = 0;
                expect_bad_length();
            end else begin
                // Close the loop back to the anchor point.
                for (int j = 0; j < d - 1; j++) begin
                    cx[j] = held_x[j];
                    cy[j] = held_y[j];
                end
                cx[d - 1] = px;
                cy[d - 1] = py;
                cx[d]     = anchor_x;
                cy[d]     = anchor_y;
                held_cnt  = 0;
                expect_segment(cx, cy, d, 1'b1);
            end
        end else if (held_cnt >= d) begin
            for (int j = 0; j < d; j++) begin
                cx[j] = held_x[j];
                cy[j] = held_y[j];
            end
            cx[d]     = px;
            cy[d]     = py;
            held_x[0] = px;
            held_y[0] = py;
            held_cnt  = 1;
            expect_segment(cx, cy, d, 1'b0);
        end else if (held_cnt < 3) begin
            held_x[held_cnt] = px;
            held_y[held_cnt] = py;
            held_cnt++;
        end
    endtask

    // Driver: bursts of random length, random gaps between them.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin : drive_points
        ctrl_point_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            // Slot is free: the held point went through or nothing was held.
            if (gap_left != 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (point_q.size() != 0) begin
                nxt = point_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.y, nxt.x};
                s_tlast  <= nxt.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switch between always-ready, coin-flip, rare stalls and stall runs.
    int rx_mode    = 0;
    int rx_left    = 0;
    int stall_left = 0;

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) != 0);
            default: begin
                if (stall_left != 0) begin
                    m_tready   <= 1'b0;
                    stall_left <= stall_left - 1;
                end else if ($urandom_range(0, 5) == 0) begin
                    m_tready   <= 1'b0;
                    stall_left <= $urandom_range(1, 8);
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Monitor: track the degree, predict on each accepted point, check each sample.
    always @(posedge aclk) begin : watch_ports
        curve_sample_t got;
        curve_sample_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                degree_reg = cfg_data;
            if (s_tvalid && s_tready) begin
                points_taken++;
                advance_curve(bcs_coord_t'(s_tdata[15:0]), bcs_coord_t'(s_tdata[31:16]),
                              s_tlast);
            end
            if (m_tvalid && m_tready) begin
                got.x          = bcs_coord_t'(m_tdata[15:0]);
                got.y          = bcs_coord_t'(m_tdata[31:16]);
                got.k          = m_tdata[35:32];
                got.seg_done   = m_tlast;
                got.curve_done = m_tuser[0];
                got.bad        = m_tuser[1];
                if (curve_samples_q.size() == 0) begin
                    report_mismatch($sformatf("sample k=%0d x=%0d y=%0d with none expected",
                                              got.k, got.x, got.y));
                end else begin
                    want = curve_samples_q.pop_front();
                    samples_checked++;
                    if (want.bad)
                        bad_results++;
                    if (got.x !== want.x)
                        report_mismatch($sformatf("k=%0d out_x %0d, want %0d",
                                                  want.k, got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("k=%0d out_y %0d, want %0d",
                                                  want.k, got.y, want.y));
                    if (got.k !== want.k)
                        report_mismatch($sformatf("sample_index %0d, want %0d",
                                                  got.k, want.k));
                    if (got.seg_done !== want.seg_done)
                        report_mismatch($sformatf("k=%0d segment_done %b, want %b",
                                                  want.k, got.seg_done, want.seg_done));
                    if (got.curve_done !== want.curve_done)
                        report_mismatch($sformatf("k=%0d curve_done %b, want %b",
                                                  want.k, got.curve_done, want.curve_done));
                    if (got.bad !== want.bad)
                        report_mismatch($sformatf("k=%0d bad_length %b, want %b",
                                                  want.k, got.bad, want.bad));
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d samples outstanding",
                     IDLE_LIMIT, curve_samples_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bcs_coord_t pick_coord();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            4, 5:    return bcs_coord_t'($urandom_range(0, 400) - 200);
            default: return bcs_coord_t'($urandom);
        endcase
    endfunction

    task automatic put_point(input bcs_coord_t x, input bcs_coord_t y, input logic last);
        ctrl_point_t p;
        p.x    = x;
        p.y    = y;
        p.last = last;
        point_q.push_back(p);
    endtask

    // Queue n random points; mark the last one when the curve is to close.
    task automatic queue_points(input int n, input bit close_it);
        for (int i = 0; i < n; i++)
            put_point(pick_coord(), pick_coord(), close_it && (i == n - 1));
    endtask

    // Hold until every point went in and every sample came out, then let
    // the pipeline drain.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (point_q.size() != 0 || s_tvalid || curve_samples_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_degree(input logic [1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        degree_writes++;
    endtask

    initial begin : stimulus
        int         random_pts;
        int         phase;
        int         phase_pts;
        int         target;
        int         d;
        int         n;
        logic [1:0] deg;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, cubic from reset: one-point curve, shortest closed curve at the
        // coordinate extremes, a two-segment curve, and two wrong lengths.
        put_point(16'sh8000, 16'sh7fff, 1'b1);
        put_point(16'sh7fff, 16'sh7fff, 1'b0);
        put_point(16'sh8000, 16'sh8000, 1'b0);
        put_point(16'sh7fff, 16'sh8000, 1'b1);
        put_point(16'sh8000, 16'sh8000, 1'b0);
        put_point(16'sh7fff, 16'sh7fff, 1'b0);
        put_point(16'sh8000, 16'sh7fff, 1'b0);
        put_point(16'sh7fff, 16'sh8000, 1'b0);
        put_point(16'sh0000, 16'sh0000, 1'b0);
        put_point(16'sh0001, 16'shffff, 1'b1);
        queue_points(2, 1'b1);
        queue_points(4, 1'b1);
        wait_idle();

        // Directed, quadratic: shortest closed curve, two segments, wrong length.
        write_degree(BCS_DEGREE_QUAD);
        put_point(16'sh7fff, 16'sh8000, 1'b0);
        put_point(16'sh8000, 16'sh7fff, 1'b1);
        queue_points(4, 1'b1);
        queue_points(3, 1'b1);

        // Random phases, one degree setting each; a phase may stop mid-curve so
        // the next setting applies to a curve already in progress.
        random_pts = 0;
        phase      = 0;
        while (random_pts < RANDOM_POINTS) begin
            case (phase)
                0:       deg = DEGREE_ZERO;
                1:       deg = BCS_DEGREE_CUBIC;
                2:       deg = DEGREE_ONE;
                3:       deg = BCS_DEGREE_QUAD;
                default: deg = 2'($urandom_range(0, 3));
            endcase
            wait_idle();
            write_degree(deg);
            d         = (deg == BCS_DEGREE_CUBIC) ? 3 : 2;
            target    = $urandom_range(30, 70);
            phase_pts = 0;
            while (phase_pts < target) begin
                case ($urandom_range(0, 11))
                    0: begin
                        // Any length, mostly broken.
                        n = $urandom_range(1, 8);
                        queue_points(n, 1'b1);
                        phase_pts += n;
                    end
                    1: begin
                        // Leave the curve open across the next degree write.
                        n = $urandom_range(1, 4);
                        queue_points(n, 1'b0);
                        phase_pts += n;
                        break;
                    end
                    default: begin
                        n = d * (($urandom_range(0, 3) == 0) ? $urandom_range(3, 5)
                                                              : $urandom_range(1, 2));
                        queue_points(n, 1'b1);
                        phase_pts += n;
                    end
                endcase
            end
            random_pts += phase_pts;
            phase++;
        end

        wait_idle();
        $display("Covered %0d control points in %0d closed curves over %0d degree writes;",
                 points_taken, curves_closed, degree_writes);
        $display("checked %0d samples, %0d of them bad-length results, %0d mismatches.",
                 samples_checked, bad_results, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
